[hdl/pll_pkg.sv]
// package: types, codes and defaults for the positional list core
`default_nettype none
package pll_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WIDTH_DEFAULT = 32;

   localparam int POS_W = 5;
   localparam int VAL_W = 32;
   localparam int CNT_OUT_W = 5;
   // compare width that covers every legal cell index
   localparam int CMP_W = 9;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_DELETE = 1'b1
   } pll_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } pll_status_type;

   typedef struct packed {
      pll_kind_type     kind;
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] value;
   } pll_req_type;

   typedef struct packed {
      pll_status_type       status;
      logic [VAL_W-1:0]     removed_value;
      logic [CNT_OUT_W-1:0] count_after;
   } pll_rsp_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic             ins;
      logic             del;
      logic [POS_W-1:0] index;
   } pll_ctrl_type;

endpackage
`default_nettype wire

[hdl/pll_cell.sv]
// one list entry: holds a value and shifts with its neighbors on insert or delete
`default_nettype none
module pll_cell
   import pll_pkg::*;
#(
   parameter int WIDTH      = WIDTH_DEFAULT,
   parameter int CELL_INDEX = 0
) (
   input  wire logic             clock,
   input  wire pll_ctrl_type     ctrl,
   input  wire logic [WIDTH-1:0] ins_value,
   input  wire logic [WIDTH-1:0] left_data,
   input  wire logic [WIDTH-1:0] right_data,
   input  wire logic [WIDTH-1:0] tap_in,
   output logic      [WIDTH-1:0] tap_out,
   output logic      [WIDTH-1:0] data_out
);

   localparam logic [CMP_W-1:0] MY_INDEX = CMP_W'(CELL_INDEX);

   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in;
   logic [CMP_W-1:0] index_ext;
   logic             hit;
   logic             above;

   assign index_ext = CMP_W'(ctrl.index);
   assign hit       = (index_ext == MY_INDEX);
   assign above     = (index_ext < MY_INDEX);

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins) begin
         if (hit) begin
            data_in = ins_value;
         end else if (above) begin
            data_in = left_data;
         end
      end else if (ctrl.del) begin
         if (hit || above) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // read tap: the addressed cell ors its value into the chain
   assign tap_out  = tap_in | (hit ? data_ff : '0);
   assign data_out = data_ff;

endmodule
`default_nettype wire

[hdl/positional_list_insert_delete_core.sv]
// top level: positional list built as a row of shifting cells
// the result is registered and valid in the cycle after a request is accepted
// throughput: one transaction per cycle while results are taken; every cell
//   shifts in the same cycle, so the cell chain sets no further limit
// reset clears the entry count and the result valid; entry values stay
//   undefined until written and need no clearing pass
`default_nettype none
module positional_list_insert_delete_core
   import pll_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int WIDTH = WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire pll_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output pll_rsp_type      rsp_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   pll_rsp_type      rsp_data_ff;
   pll_rsp_type      rsp_data_in;

   logic             req_fire;
   logic [CW-1:0]    pos_c;
   logic [CW-1:0]    cnt_c;
   logic             pos_nonzero;
   logic             ins_range_ok;
   logic             del_range_ok;
   logic             full;
   pll_status_type   status;
   pll_ctrl_type     ctrl;
   logic [WIDTH-1:0] ins_value;

   logic [WIDTH-1:0] cell_data [DEPTH];
   logic [WIDTH-1:0] tap_chain [DEPTH+1];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   assign pos_c        = CW'(req_data.position);
   assign cnt_c        = CW'(count_ff);
   assign pos_nonzero  = (req_data.position != '0);
   assign ins_range_ok = pos_nonzero && (pos_c <= cnt_c + CW'(1));
   assign del_range_ok = pos_nonzero && (pos_c <= cnt_c);
   assign full         = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      status = STATUS_OK;
      unique case (req_data.kind)
         KIND_INSERT: begin
            if (!ins_range_ok) begin
               status = STATUS_RANGE;
            end else if (full) begin
               status = STATUS_FULL;
            end
         end
         KIND_DELETE: begin
            if (!del_range_ok) begin
               status = STATUS_RANGE;
            end
         end
         default: status = STATUS_RANGE;
      endcase
   end

   always_comb begin
      ctrl.ins   = req_fire && (req_data.kind == KIND_INSERT) && (status == STATUS_OK);
      ctrl.del   = req_fire && (req_data.kind == KIND_DELETE) && (status == STATUS_OK);
      ctrl.index = req_data.position - POS_W'(1);
   end

   assign ins_value    = WIDTH'(req_data.value);
   assign tap_chain[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WIDTH-1:0] left_data;
      logic [WIDTH-1:0] right_data;
      if (i == 0) begin : g_first
         assign left_data = ins_value;
      end else begin : g_mid
         assign left_data = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_inner
         assign right_data = cell_data[i+1];
      end
      pll_cell #(
         .WIDTH      (WIDTH),
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .ins_value  (ins_value),
         .left_data  (left_data),
         .right_data (right_data),
         .tap_in     (tap_chain[i]),
         .tap_out    (tap_chain[i+1]),
         .data_out   (cell_data[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.del) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_data_in.status        = status;
      rsp_data_in.removed_value = ctrl.del ? VAL_W'(tap_chain[DEPTH]) : '0;
      rsp_data_in.count_after   = CNT_OUT_W'(count_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // entry count never passes the list depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   // a rejected transaction leaves the list length alone
   a_reject_keeps_count: assert property (@(posedge clock) disable iff (reset)
      req_fire && (status != STATUS_OK) |=> $stable(count_ff))
      else $error("count moved on a rejected transaction");

   // a successful delete shortens the list by exactly one
   a_delete_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.del |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("delete did not shorten the list by one");

   // a full report only comes with a full list
   a_full_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status == STATUS_FULL)
         |-> rsp_data_ff.count_after == CNT_OUT_W'(DEPTH))
      else $error("full status with list not full");

endmodule
`default_nettype wire

[dv/positional_list_insert_delete_core_tb.sv]
// testbench: positional list core checked against an in-bench list predictor
module positional_list_insert_delete_core_tb;
   import pll_pkg::*;

   localparam int LIST_DEPTH = DEPTH_DEFAULT;
   localparam int DRAIN_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   pll_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   pll_rsp_type rsp_data;

   positional_list_insert_delete_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // shadow copy of the list, updated as each transaction is accepted
   logic [VAL_W-1:0] list_entries [0:LIST_DEPTH-1];
   int               list_len = 0;
   pll_rsp_type      expected_rsp_q [$];

   bit          idle_on = 1'b1;
   bit          stall_on = 1'b1;
   int unsigned sent_cnt = 0;
   int unsigned checked_cnt = 0;
   int unsigned err_cnt = 0;
   int unsigned ok_cnt = 0;
   int unsigned range_cnt = 0;
   int unsigned full_cnt = 0;
   int unsigned peak_len = 0;

   function automatic pll_rsp_type apply_list_op(input pll_req_type op);
      pll_rsp_type r;
      int          idx;
      r.status = STATUS_OK;
      r.removed_value = '0;
      idx = int'(op.position) - 1;
      if (op.kind == KIND_INSERT) begin
         if (op.position < 1 || int'(op.position) > list_len + 1) begin
            r.status = STATUS_RANGE;
         end else if (list_len >= LIST_DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            for (int k = list_len; k > idx; k--) list_entries[k] = list_entries[k-1];
            list_entries[idx] = op.value;
            list_len++;
         end
      end else begin
         if (op.position < 1 || int'(op.position) > list_len) begin
            r.status = STATUS_RANGE;
         end else begin
            r.removed_value = list_entries[idx];
            for (int k = idx; k + 1 < list_len; k++) list_entries[k] = list_entries[k+1];
            list_len--;
         end
      end
      if (list_len > int'(peak_len)) peak_len = unsigned'(list_len);
      r.count_after = CNT_OUT_W'(list_len);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
      err_cnt++;
   endtask

   task automatic send_op(input pll_kind_type op_kind, input logic [POS_W-1:0] op_pos,
                          input logic [VAL_W-1:0] op_val);
      pll_req_type op;
      op.kind = op_kind;
      op.position = op_pos;
      op.value = op_val;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= op;
      do @(posedge clock); while (req_stall);
      expected_rsp_q.push_back(apply_list_op(op));
      sent_cnt++;
   endtask

   // hold off the sender until every outstanding result is back or the drain limit runs out
   task automatic wait_all_results();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (expected_rsp_q.size() != 0 && waited < DRAIN_LIMIT);
      if (expected_rsp_q.size() != 0)
         report_mismatch("results never arrived", 32'(expected_rsp_q.size()), 32'd0);
      repeat (2) @(posedge clock);
   endtask

   task automatic test_empty_list();
      send_op(KIND_DELETE, 5'd1, 32'h0000_0000);
      send_op(KIND_DELETE, 5'd31, 32'hFFFF_FFFF);
      send_op(KIND_INSERT, 5'd0, 32'hFFFF_FFFF);
      send_op(KIND_INSERT, 5'd2, 32'h0000_0001);
   endtask

   task automatic test_fill_and_full();
      logic [POS_W-1:0] p;
      logic [VAL_W-1:0] v;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         // rotate between front, back and middle placement
         case (i % 3)
            0: begin
               p = 5'd1;
            end
            1: begin
               p = POS_W'(list_len + 1);
            end
            default: begin
               p = POS_W'(list_len / 2 + 1);
            end
         endcase
         case (i)
            0: begin
               v = 32'h0000_0000;
            end
            1: begin
               v = 32'hFFFF_FFFF;
            end
            2: begin
               v = 32'h8000_0000;
            end
            3: begin
               v = 32'h5555_5555;
            end
            4: begin
               v = 32'hAAAA_AAAA;
            end
            default: begin
               v = $urandom();
            end
         endcase
         send_op(KIND_INSERT, p, v);
      end
      // full list: in-range insert rejected as full, out-of-range as range
      send_op(KIND_INSERT, 5'd17, 32'h1234_5678);
      send_op(KIND_INSERT, 5'd1, 32'h1234_5678);
      send_op(KIND_INSERT, 5'd18, 32'h1234_5678);
      send_op(KIND_DELETE, 5'd17, $urandom());
      send_op(KIND_DELETE, 5'd0, $urandom());
      send_op(KIND_DELETE, 5'd16, $urandom());
      send_op(KIND_DELETE, 5'd1, $urandom());
      send_op(KIND_DELETE, 5'd7, $urandom());
   endtask

   task automatic test_random_ops(input int n_items, input bit with_idle);
      int           insert_pct;
      int           span;
      pll_kind_type k;
      logic [POS_W-1:0] p;
      insert_pct = 50;
      for (int i = 0; i < n_items; i++) begin
         if (i % 40 == 0) begin
            // drift the fill level toward empty, balanced or toward full, picked at random
            case ($urandom_range(0, 2))
               0: begin
                  insert_pct = 20;
               end
               1: begin
                  insert_pct = 50;
               end
               default: begin
                  insert_pct = 85;
               end
            endcase
            idle_on = with_idle && ((i / 40) % 4 != 3);
            stall_on = idle_on;
            if (with_idle && $urandom_range(0, 4) == 0) wait_all_results();
         end
         k = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_DELETE;
         span = (k == KIND_INSERT) ? list_len + 1 : list_len;
         if (span == 0 || $urandom_range(0, 9) == 0) p = POS_W'($urandom_range(0, 31));
         else p = POS_W'($urandom_range(1, span));
         send_op(k, p, $urandom());
      end
   endtask

   always @(posedge clock) begin
      pll_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         checked_cnt++;
         case (rsp_data.status)
            STATUS_OK: begin
               ok_cnt++;
            end
            STATUS_RANGE: begin
               range_cnt++;
            end
            STATUS_FULL: begin
               full_cnt++;
            end
            default: begin
            end
         endcase
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("result with no transaction outstanding",
                            32'(rsp_data.status), 32'd0);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            if (rsp_data.removed_value !== want.removed_value)
               report_mismatch("removed_value", rsp_data.removed_value, want.removed_value);
            if (rsp_data.count_after !== want.count_after)
               report_mismatch("count_after", 32'(rsp_data.count_after),
                               32'(want.count_after));
         end
      end
   end

   // result-side backpressure in random bursts
   initial begin
      wait (!reset);
      @(posedge clock);
      forever begin
         if (stall_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
      end
   end

   initial begin
      #4000000;
      $display("timeout waiting on the list core");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_fill_and_full();
      test_random_ops(1200, 1'b1);
      wait_all_results();
      test_random_ops(200, 1'b0);
      wait_all_results();
      $display("sent %0d transactions, checked %0d results", sent_cnt, checked_cnt);
      $display("statuses seen: %0d ok, %0d range, %0d full; peak list length %0d",
               ok_cnt, range_cnt, full_cnt, peak_len);
      if (err_cnt == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[files.f]
hdl/pll_pkg.sv
hdl/pll_cell.sv
hdl/positional_list_insert_delete_core.sv
dv/positional_list_insert_delete_core_tb.sv
